FILE: hw/rtl/ptu_pkg.sv
// Shared types and constants for the particle table update unit.
// No dependencies; imported by every module of the block.
package ptu_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int DATA_W          = 32;
    localparam int SLOT_W          = 6;
    localparam int COUNT_W         = 7;
    localparam int NUM_W           = 40;   // colour numerator, below 256 * lifetime
    localparam int PROD_W          = 64;   // 33 x 33 signed product, kept to 64 bits

    localparam logic KIND_CREATE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // One table row
    typedef struct packed {
        logic [DATA_W-1:0] pos_x;
        logic [DATA_W-1:0] pos_y;
        logic [DATA_W-1:0] vel_x;
        logic [DATA_W-1:0] vel_y;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] init;
        logic [DATA_W-1:0] start_rgba;
        logic [DATA_W-1:0] end_rgba;
    } ptu_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CNT_RD,
        ST_CNT_CHK,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_MUL_X,
        ST_ADD_X,
        ST_ADD_Y,
        ST_MUL_S,
        ST_MUL_E,
        ST_SUM,
        ST_DIV,
        ST_EMIT,
        ST_EMPTY
    } ptu_state_t;

    // Divider request
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DATA_W-1:0] den;
    } ptu_div_req_t;

endpackage

FILE: hw/rtl/ptu_mul.sv
// Shared signed 33 x 33 multiplier with a registered product.
// Depends on ptu_pkg.
module ptu_mul (
    input  logic                        aclk,
    input  logic signed [32:0]          a,
    input  logic signed [32:0]          b,
    output logic signed [ptu_pkg::PROD_W-1:0] p_reg
);
    import ptu_pkg::*;

    logic signed [65:0] full;

    // products used here always fit in 64 bits
    assign full = a * b;

    always_ff @(posedge aclk) begin
        p_reg <= full[PROD_W-1:0];
    end
endmodule

FILE: hw/rtl/ptu_div.sv
// Restoring divider, one quotient bit per cycle, 8-bit quotient.
// Depends on ptu_pkg; the numerator must be below 256 times the divisor.
module ptu_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ptu_pkg::ptu_div_req_t req,
    output logic                 done,
    output logic [7:0]           quo
);
    import ptu_pkg::*;

    logic [DATA_W-1:0] part_reg, part_next;
    logic [7:0]        low_reg, low_next;
    logic [DATA_W-1:0] den_reg, den_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   trial;
    logic              fits;

    assign trial = {part_reg, low_reg[7]};
    assign fits  = trial >= {1'b0, den_reg};

    // one step of long division
    always_comb begin
        part_next = part_reg;
        low_next  = low_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            part_next = req.num[NUM_W-1:8];
            low_next  = req.num[7:0];
            den_next  = req.den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            part_next = fits ? DATA_W'(trial - {1'b0, den_reg}) : trial[DATA_W-1:0];
            low_next  = {low_reg[6:0], fits};
            cnt_next  = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        part_reg <= part_next;
        low_reg  <= low_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign quo  = low_reg;
endmodule

FILE: hw/rtl/particle_table_update_unit.sv
// Particle table update unit. A create transaction gives one result.
// A tick first counts the survivors in one pass over the live slots, so that every result carries
// the final live count, then walks the table: a removed slot is filled from the tail entry unless
// it is the tail itself, and a survivor goes through the shared multiplier for its x and y steps,
// then through the multiplier and the bit-serial colour divider once for each of four channels.
// The unit takes no input while a tick is in progress or while a result waits in the output register.
// The table memory needs no clearing.
module particle_table_update_unit #(
    parameter int TABLE_DEPTH = ptu_pkg::TABLE_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_kind,
    input  logic signed [31:0]          s_pos_x,
    input  logic signed [31:0]          s_pos_y,
    input  logic signed [31:0]          s_vel_x,
    input  logic signed [31:0]          s_vel_y,
    input  logic [31:0]                 s_life_span,
    input  logic [31:0]                 s_start_rgba,
    input  logic [31:0]                 s_end_rgba,
    input  logic [31:0]                 s_tick_step,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_has_particle,
    output logic [ptu_pkg::SLOT_W-1:0]  m_slot,
    output logic signed [31:0]          m_out_x,
    output logic signed [31:0]          m_out_y,
    output logic [31:0]                 m_out_rgba,
    output logic                        m_accepted,
    output logic [ptu_pkg::COUNT_W-1:0] m_live_count,
    output logic                        m_last
);
    import ptu_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(TABLE_DEPTH);

    // table memory
    ptu_entry_t       mem [TABLE_DEPTH];
    ptu_entry_t       rdata_reg;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    ptu_entry_t       wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // sequencer state
    ptu_state_t        state_reg, state_next;
    logic [COUNT_W-1:0] live_reg, live_next;
    logic [COUNT_W-1:0] surv_reg, surv_next;
    logic [COUNT_W-1:0] idx_reg, idx_next;
    logic [COUNT_W-1:0] walk_reg, walk_next;
    logic [COUNT_W-1:0] emit_reg, emit_next;
    logic [DATA_W-1:0]  dt_reg, dt_next;
    ptu_entry_t         ent_reg, ent_next;
    logic [1:0]         chan_reg, chan_next;
    logic [NUM_W-1:0]   prods_reg, prods_next;
    logic [DATA_W-1:0]  color_reg, color_next;

    // output register
    logic               mv_reg, mv_next;
    logic               out_load;
    logic               o_has, o_acc, o_last;
    logic [SLOT_W-1:0]  o_slot;
    logic [DATA_W-1:0]  o_x, o_y, o_rgba;
    logic [COUNT_W-1:0] o_live;
    logic               has_reg, acc_reg, last_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [DATA_W-1:0]  x_reg, y_reg, rgba_reg;
    logic [COUNT_W-1:0] lc_reg;

    // shared units
    logic signed [32:0]       mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    ptu_div_req_t             dreq;
    logic                     div_done;
    logic [7:0]               div_quo;

    ptu_mul u_mul (.aclk(aclk), .a(mul_a), .b(mul_b), .p_reg(mul_p));
    ptu_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .done(div_done),
                   .quo(div_quo));

    // datapath helpers
    logic               accept;
    logic [DATA_W-1:0]  rem_c, elapsed;
    logic [7:0]         cs, ce;
    logic signed [48:0] sum49;
    logic signed [DATA_W-1:0] pos_sel, pos_sat;
    logic [COUNT_W-1:0] tail;
    logic [NUM_W:0]     num_full;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE) && !mv_reg;
    assign rem_c   = (ent_reg.rem > ent_reg.init) ? ent_reg.init : ent_reg.rem;
    assign elapsed = ent_reg.init - rem_c;
    assign cs      = ent_reg.start_rgba[{chan_reg, 3'b000} +: 8];
    assign ce      = ent_reg.end_rgba[{chan_reg, 3'b000} +: 8];
    assign tail    = walk_reg - COUNT_W'(1);
    assign num_full = {1'b0, prods_reg} + (NUM_W+1)'(mul_p[NUM_W-1:0])
                    + (NUM_W+1)'(ent_reg.init >> 1);

    // position step: p + floor(v*dt / 2^16), saturated
    assign pos_sel = (state_reg == ST_ADD_X) ? $signed(ent_reg.pos_x) : $signed(ent_reg.pos_y);
    assign sum49   = 49'(pos_sel) + 49'($signed(mul_p[PROD_W-1:16]));
    always_comb begin
        if (sum49 > 49'sd2147483647) begin
            pos_sat = 32'sh7FFFFFFF;
        end else if (sum49 < -49'sd2147483648) begin
            pos_sat = 32'sh80000000;
        end else begin
            pos_sat = sum49[DATA_W-1:0];
        end
    end

    // next state and outputs
    always_comb begin
        state_next = state_reg;
        live_next  = live_reg;
        surv_next  = surv_reg;
        idx_next   = idx_reg;
        walk_next  = walk_reg;
        emit_next  = emit_reg;
        dt_next    = dt_reg;
        ent_next   = ent_reg;
        chan_next  = chan_reg;
        prods_next = prods_reg;
        color_next = color_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg[IDX_W-1:0];
        wr_data    = ent_reg;
        rd_addr    = idx_reg[IDX_W-1:0];
        mul_a      = '0;
        mul_b      = '0;
        dreq       = '0;
        out_load   = 1'b0;
        o_has      = 1'b0;
        o_acc      = 1'b0;
        o_last     = 1'b1;
        o_slot     = '0;
        o_x        = '0;
        o_y        = '0;
        o_rgba     = '0;
        o_live     = live_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_kind == KIND_CREATE) begin
                        out_load = 1'b1;
                        if (live_reg < DEPTH_C) begin
                            wr_en   = 1'b1;
                            wr_addr = live_reg[IDX_W-1:0];
                            wr_data = '{pos_x: s_pos_x, pos_y: s_pos_y, vel_x: s_vel_x,
                                        vel_y: s_vel_y, rem: s_life_span, init: s_life_span,
                                        start_rgba: s_start_rgba, end_rgba: s_end_rgba};
                            live_next = live_reg + COUNT_W'(1);
                            o_has  = 1'b1;
                            o_acc  = 1'b1;
                            o_slot = live_reg[SLOT_W-1:0];
                            o_x    = s_pos_x;
                            o_y    = s_pos_y;
                            o_rgba = s_start_rgba;
                            o_live = live_next;
                        end
                    end else begin
                        dt_next    = s_tick_step;
                        idx_next   = '0;
                        surv_next  = '0;
                        state_next = ST_CNT_RD;
                    end
                end
            end
            // survivor count pass
            ST_CNT_RD: begin
                if (idx_reg >= live_reg) begin
                    idx_next   = '0;
                    walk_next  = live_reg;
                    emit_next  = '0;
                    state_next = ST_WALK_RD;
                end else begin
                    state_next = ST_CNT_CHK;
                end
            end
            ST_CNT_CHK: begin
                if (dt_reg < rdata_reg.rem) begin
                    surv_next = surv_reg + COUNT_W'(1);
                end
                idx_next   = idx_reg + COUNT_W'(1);
                state_next = ST_CNT_RD;
            end
            // update walk
            ST_WALK_RD: begin
                if (idx_reg >= walk_reg) begin
                    live_next  = surv_reg;
                    state_next = (surv_reg == '0) ? ST_EMPTY : ST_IDLE;
                end else begin
                    state_next = ST_WALK_CHK;
                end
            end
            ST_WALK_CHK: begin
                if (dt_reg >= rdata_reg.rem) begin
                    walk_next  = tail;
                    state_next = (idx_reg != tail) ? ST_MOVE_RD : ST_WALK_RD;
                end else begin
                    ent_next     = rdata_reg;
                    ent_next.rem = rdata_reg.rem - dt_reg;
                    state_next   = ST_MUL_X;
                end
            end
            ST_MOVE_RD: begin
                rd_addr    = walk_reg[IDX_W-1:0];
                state_next = ST_MOVE_WR;
            end
            ST_MOVE_WR: begin
                wr_en      = 1'b1;
                wr_data    = rdata_reg;
                state_next = ST_WALK_RD;
            end
            ST_MUL_X: begin
                mul_a      = 33'($signed(ent_reg.vel_x));
                mul_b      = {1'b0, dt_reg};
                state_next = ST_ADD_X;
            end
            ST_ADD_X: begin
                ent_next.pos_x = pos_sat;
                mul_a          = 33'($signed(ent_reg.vel_y));
                mul_b          = {1'b0, dt_reg};
                state_next     = ST_ADD_Y;
            end
            ST_ADD_Y: begin
                ent_next.pos_y = pos_sat;
                chan_next      = '0;
                state_next     = ST_MUL_S;
            end
            // colour mix, one channel at a time
            ST_MUL_S: begin
                mul_a      = {25'b0, cs};
                mul_b      = {1'b0, rem_c};
                state_next = ST_MUL_E;
            end
            ST_MUL_E: begin
                prods_next = mul_p[NUM_W-1:0];
                mul_a      = {25'b0, ce};
                mul_b      = {1'b0, elapsed};
                state_next = ST_SUM;
            end
            ST_SUM: begin
                dreq.start = 1'b1;
                dreq.num   = num_full[NUM_W-1:0];
                dreq.den   = ent_reg.init;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    color_next[{chan_reg, 3'b000} +: 8] = (ent_reg.init == '0) ? ce : div_quo;
                    chan_next  = chan_reg + 2'd1;
                    state_next = (chan_reg == 2'd3) ? ST_EMIT : ST_MUL_S;
                end
            end
            ST_EMIT: begin
                wr_en = 1'b1;
                if (!mv_reg) begin
                    out_load   = 1'b1;
                    o_has      = 1'b1;
                    o_slot     = idx_reg[SLOT_W-1:0];
                    o_x        = ent_reg.pos_x;
                    o_y        = ent_reg.pos_y;
                    o_rgba     = color_reg;
                    o_live     = surv_reg;
                    o_last     = (emit_reg + COUNT_W'(1)) == surv_reg;
                    emit_next  = emit_reg + COUNT_W'(1);
                    idx_next   = idx_reg + COUNT_W'(1);
                    state_next = ST_WALK_RD;
                end
            end
            ST_EMPTY: begin
                if (!mv_reg) begin
                    out_load   = 1'b1;
                    o_live     = '0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign mv_next = out_load ? 1'b1 : (mv_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            live_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            live_reg  <= live_next;
            mv_reg    <= mv_next;
        end
        surv_reg  <= surv_next;
        idx_reg   <= idx_next;
        walk_reg  <= walk_next;
        emit_reg  <= emit_next;
        dt_reg    <= dt_next;
        ent_reg   <= ent_next;
        chan_reg  <= chan_next;
        prods_reg <= prods_next;
        color_reg <= color_next;
        if (out_load) begin
            has_reg  <= o_has;
            acc_reg  <= o_acc;
            last_reg <= o_last;
            slot_reg <= o_slot;
            x_reg    <= o_x;
            y_reg    <= o_y;
            rgba_reg <= o_rgba;
            lc_reg   <= o_live;
        end
    end

    assign m_valid        = mv_reg;
    assign m_has_particle = has_reg;
    assign m_slot         = slot_reg;
    assign m_out_x        = x_reg;
    assign m_out_y        = y_reg;
    assign m_out_rgba     = rgba_reg;
    assign m_accepted     = acc_reg;
    assign m_live_count   = lc_reg;
    assign m_last         = last_reg;

    // checks
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == ST_IDLE))
        else $error("input ready outside idle");
    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= DEPTH_C)
        else $error("live count above table depth");
    a_acc_has: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && acc_reg) |-> has_reg)
        else $error("accepted create without particle");
    a_surv_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK_RD) |->
        ((COUNT_W+1)'(surv_reg) <= (COUNT_W+1)'(walk_reg) + (COUNT_W+1)'(emit_reg)))
        else $error("survivor count out of step with walk");
endmodule
